>>> rtl/core/integer_to_ascii_formatter_assert.svh
// Assertion macros for the integer to ASCII formatter.
// Included by the RTL files that check their own sequencing; needs no package.
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication: cons holds whenever ante holds.
`define ITOA_ASSERT_IMPL(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("itoa same-cycle check failed");
// Next-cycle implication: cons holds in the cycle after ante.
`define ITOA_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("itoa next-cycle check failed");
`else
`define ITOA_ASSERT_IMPL(label, ck, rs, ante, cons)
`define ITOA_ASSERT_NEXT(label, ck, rs, ante, cons)
`endif
`endif

>>> rtl/core/itoa_pkg.sv
// Shared types, codes and character helpers for the integer to ASCII formatter.
// No dependencies; used by the top level.
package itoa_pkg;

  // Format select codes
  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_DEC    = 2'd0;
  localparam opcode_t OP_HEX_LO = 2'd1;
  localparam opcode_t OP_HEX_UP = 2'd2;
  localparam opcode_t OP_PTR    = 2'd3;

  // ASCII codes
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LOWER  = 8'h61;
  localparam logic [7:0] CH_UPPER  = 8'h41;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_I      = 8'h69;
  localparam logic [7:0] CH_L      = 8'h6c;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  // Input and output items
  typedef struct packed {
    opcode_t     opcode;
    logic [63:0] value;
  } req_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } rsp_t;

  // Text sent ahead of the digits
  typedef enum logic [1:0] {
    PK_NONE  = 2'd0,
    PK_MINUS = 2'd1,
    PK_0X    = 2'd2,
    PK_NIL   = 2'd3
  } prefix_t;

  // Index of the final character of a prefix
  function automatic logic [2:0] prefix_last(input prefix_t kind);
    logic [2:0] idx;
    case (kind)
      PK_0X:   idx = 3'd1;
      PK_NIL:  idx = 3'd4;
      default: idx = 3'd0;
    endcase
    return idx;
  endfunction

  // Character at position idx of a prefix
  function automatic logic [7:0] prefix_char(input prefix_t kind, input logic [2:0] idx);
    logic [7:0] ch;
    case (kind)
      PK_MINUS: ch = CH_MINUS;
      PK_0X:    ch = (idx == 3'd0) ? CH_ZERO : CH_X;
      PK_NIL: begin
        case (idx)
          3'd0:    ch = CH_LPAREN;
          3'd1:    ch = CH_N;
          3'd2:    ch = CH_I;
          3'd3:    ch = CH_L;
          default: ch = CH_RPAREN;
        endcase
      end
      default:  ch = CH_ZERO;
    endcase
    return ch;
  endfunction

  // One digit (decimal or hex) to ASCII
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] ch;
    if (d < 4'd10) begin
      ch = CH_ZERO + {4'h0, d};
    end else if (upper) begin
      ch = CH_UPPER + {4'h0, d} - 8'd10;
    end else begin
      ch = CH_LOWER + {4'h0, d} - 8'd10;
    end
    return ch;
  endfunction

endpackage

>>> rtl/core/itoa_bcd_conv.sv
// Iterative binary to BCD converter (shift and add-3), one bit per cycle.
// Standalone; instantiated by integer_to_ascii_formatter.
module itoa_bcd_conv #(
  parameter int VALUE_BITS = 64,
  parameter int DIGITS     = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] magnitude,
  output logic                  done,
  output logic [DIGITS*4-1:0]   bcd
);

  localparam int CW = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] bin;
  logic [DIGITS*4-1:0]   bcd_adj;
  logic [CW-1:0]         count;

  // add-3 correction on every digit lane
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  // bit counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CW'(VALUE_BITS);
    end else if (count != '0) begin
      count <= count - 1'b1;
    end
  end

  // shift the next binary bit into the corrected digits
  always_ff @(posedge clk) begin
    if (start) begin
      bin <= magnitude;
      bcd <= '0;
    end else if (count != '0) begin
      bcd <= {bcd_adj[DIGITS*4-2:0], bin[VALUE_BITS-1]};
      bin <= {bin[VALUE_BITS-2:0], 1'b0};
    end
  end

  assign done = (count == '0);

endmodule

>>> rtl/core/integer_to_ascii_formatter.sv
// Integer to ASCII formatter: signed decimal, hex and pointer text, one character per item.
// Depends on itoa_pkg, itoa_bcd_conv and integer_to_ascii_formatter_assert.svh.
//
// One request is taken at a time and its text leaves as one character per output item,
// the last flagged. A decimal request first runs the shift-and-add-3 converter. For
// every request but a nil pointer, leading zero digits are then dropped at one per cycle,
// and the remaining digits are sent in order, each when the output register is free.
// Dropped and sent digits together always number DEC_DIGITS for a decimal request, and
// a minus sign goes ahead of the digits of a negative value. Hex requests skip the
// converter. A pointer adds the prefix "0x", and a nil pointer sends "(nil)" alone. The
// text passes through a single output register, and output stalls hold the prefix and
// digit states. The request side is ready again as soon as the final character sits in
// the output register.
`include "integer_to_ascii_formatter_assert.svh"
module integer_to_ascii_formatter import itoa_pkg::*; #(
  parameter int VALUE_BITS = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int DEC_DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int BUF_DIGITS = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
  localparam int BW         = BUF_DIGITS * 4;
  localparam int CW         = $clog2(BUF_DIGITS + 1);
  localparam int HEX_SHIFT  = (BUF_DIGITS - HEX_DIGITS) * 4;
  localparam int DEC_SHIFT  = (BUF_DIGITS - DEC_DIGITS) * 4;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CONV = 5'b00010,
    S_SKIP = 5'b00100,
    S_PRE  = 5'b01000,
    S_DIG  = 5'b10000
  } state_t;

  state_t                  state;
  logic [BW-1:0]           digit_buf;
  logic [CW-1:0]           dig_left;
  prefix_t                 pre_kind;
  logic [2:0]              pre_idx;
  logic                    upper;
  logic [VALUE_BITS-1:0]   value_in;
  logic                    negative;
  logic [VALUE_BITS-1:0]   magnitude;
  logic [BW-1:0]           hex_load;
  logic                    accept;
  logic                    emit_ok;
  logic                    emit;
  logic                    conv_start;
  logic                    conv_done;
  logic [DEC_DIGITS*4-1:0] bcd;
  logic [3:0]              top_digit;
  logic                    pre_end;

  // request decode
  assign value_in   = req.value[VALUE_BITS-1:0];
  assign negative   = value_in[VALUE_BITS-1];
  assign magnitude  = negative ? (~value_in) + {{(VALUE_BITS-1){1'b0}}, 1'b1} : value_in;
  assign hex_load   = BW'(value_in) << HEX_SHIFT;
  assign req_ready  = (state == S_IDLE);
  assign accept     = req_valid && req_ready;
  assign conv_start = accept && (req.opcode == OP_DEC);
  assign emit_ok    = !rsp_valid || rsp_ready;
  assign emit       = (state == S_PRE || state == S_DIG) && emit_ok;
  assign top_digit  = digit_buf[BW-1 -: 4];
  assign pre_end    = (pre_idx == prefix_last(pre_kind));

  itoa_bcd_conv #(
    .VALUE_BITS (VALUE_BITS),
    .DIGITS     (DEC_DIGITS)
  ) u_conv (
    .clk       (clk),
    .rst       (rst),
    .start     (conv_start),
    .magnitude (magnitude),
    .done      (conv_done),
    .bcd       (bcd)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      dig_left  <= '0;
      pre_kind  <= PK_NONE;
      pre_idx   <= '0;
    end else begin
      // output register holds its item until taken
      rsp_valid <= emit || (rsp_valid && !rsp_ready);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pre_idx <= '0;
            case (req.opcode)
              OP_DEC: begin
                state    <= S_CONV;
                dig_left <= CW'(DEC_DIGITS);
                pre_kind <= negative ? PK_MINUS : PK_NONE;
              end
              OP_PTR: begin
                dig_left <= CW'(HEX_DIGITS);
                if (value_in == '0) begin
                  state    <= S_PRE;
                  pre_kind <= PK_NIL;
                end else begin
                  state    <= S_SKIP;
                  pre_kind <= PK_0X;
                end
              end
              default: begin
                state    <= S_SKIP;
                dig_left <= CW'(HEX_DIGITS);
                pre_kind <= PK_NONE;
              end
            endcase
          end
        end
        S_CONV: begin
          if (conv_done) begin
            state <= S_SKIP;
          end
        end
        S_SKIP: begin
          if (top_digit == 4'd0 && dig_left > CW'(1)) begin
            dig_left <= dig_left - 1'b1;
          end else begin
            state <= (pre_kind == PK_NONE) ? S_DIG : S_PRE;
          end
        end
        S_PRE: begin
          if (emit_ok) begin
            pre_idx   <= pre_idx + 3'd1;
            if (pre_end) begin
              state <= (pre_kind == PK_NIL) ? S_IDLE : S_DIG;
            end
          end
        end
        S_DIG: begin
          if (emit_ok) begin
            dig_left  <= dig_left - 1'b1;
            if (dig_left == CW'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // digit buffer and output register
  always_ff @(posedge clk) begin
    if (accept) begin
      upper     <= (req.opcode == OP_HEX_UP);
      digit_buf <= hex_load;
    end else if (state == S_CONV && conv_done) begin
      digit_buf <= BW'(bcd) << DEC_SHIFT;
    end else if (state == S_SKIP && top_digit == 4'd0 && dig_left > CW'(1)) begin
      digit_buf <= digit_buf << 4;
    end else if (state == S_DIG && emit_ok) begin
      digit_buf <= digit_buf << 4;
    end
    if (state == S_PRE && emit_ok) begin
      rsp.character <= prefix_char(pre_kind, pre_idx);
      rsp.last      <= (pre_kind == PK_NIL) && pre_end;
    end else if (state == S_DIG && emit_ok) begin
      rsp.character <= digit_char(top_digit, upper);
      rsp.last      <= (dig_left == CW'(1));
    end
  end

  // sequencing checks
  `ITOA_ASSERT_IMPL(a_dig_has_digits, clk, rst, state == S_DIG, dig_left != '0)
  `ITOA_ASSERT_IMPL(a_pre_has_text, clk, rst, state == S_PRE, pre_kind != PK_NONE)
  `ITOA_ASSERT_NEXT(a_accept_busy, clk, rst, req_valid && req_ready, !req_ready)
  `ITOA_ASSERT_NEXT(a_conv_wait, clk, rst, state == S_CONV && !conv_done, state == S_CONV)
  `ITOA_ASSERT_NEXT(a_final_digit, clk, rst, state == S_DIG && emit_ok && dig_left == CW'(1), state == S_IDLE && rsp_valid && rsp.last)

endmodule
